// ===== hdl/cp15m_pkg.sv =====
// shared types and constants for the cp15 mpu coprocessor register block
// no dependencies; used by the decoder, top level and bench
`default_nettype none

package cp15m_pkg;

    localparam logic [31:0] CTRL_SET_MASK     = 32'h0000_0070;
    localparam logic [31:0] CTRL_CLEAR_MASK   = 32'hfff0_0f02;
    localparam logic [31:0] CTRL_READ_SET     = 32'h0000_0002;
    localparam logic [31:0] CTRL_RESET        = 32'h0000_0078;
    localparam logic [31:0] REGION_WRITE_MASK = 32'hffff_f07f;

    localparam int CTRL_HIVEC_BIT = 13;
    localparam int CTRL_MPU_BIT   = 0;

    // primary register numbers
    localparam logic [3:0] CRN_ID     = 4'd0;
    localparam logic [3:0] CRN_CTRL   = 4'd1;
    localparam logic [3:0] CRN_CACHE  = 4'd2;
    localparam logic [3:0] CRN_BUFFER = 4'd3;
    localparam logic [3:0] CRN_AP     = 4'd5;
    localparam logic [3:0] CRN_REGION = 4'd6;
    localparam logic [3:0] CRN_CACHOP = 4'd7;
    localparam logic [3:0] CRN_LOCK   = 4'd9;

    // configuration register indexes
    localparam logic CFG_MAIN_ID    = 1'b0;
    localparam logic CFG_CACHE_TYPE = 1'b1;

    typedef struct packed {
        logic        ok;
        logic        rd;
        logic        ctrl_we;
        logic        ram_we;
        logic        ram_re;
        logic        fl_all;
        logic        fl_line;
        logic [31:0] imm;
    } t_dec;

endpackage

`default_nettype wire

// ===== hdl/cp15m_if.sv =====
// request and response channel interfaces for the cp15 mpu register block
// no dependencies
`default_nettype none

interface cp15m_req_if;
    logic        valid;
    logic        ready;
    logic        is_read;
    logic        is_double;
    logic [2:0]  opcode1;
    logic [3:0]  primary_reg;
    logic [3:0]  secondary_reg;
    logic [2:0]  opcode2;
    logic [31:0] write_data;

    modport source (output valid, is_read, is_double, opcode1, primary_reg,
                    secondary_reg, opcode2, write_data, input ready);
    modport sink   (input valid, is_read, is_double, opcode1, primary_reg,
                    secondary_reg, opcode2, write_data, output ready);
endinterface

interface cp15m_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] read_data;
    logic        high_vectors;
    logic        mpu_enable;
    logic        icache_flush_all;
    logic        icache_flush_line;
    logic [31:0] flush_address;

    modport source (output valid, accepted, read_data, high_vectors, mpu_enable,
                    icache_flush_all, icache_flush_line, flush_address, input ready);
    modport sink   (input valid, accepted, read_data, high_vectors, mpu_enable,
                    icache_flush_all, icache_flush_line, flush_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/cp15m_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cp15m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// ===== hdl/cp15m_dec.sv =====
// decoder for one coprocessor transfer: acceptance, storage access and flushes
// depends on cp15m_pkg
`default_nettype none

module cp15m_dec #(
    parameter int REGIONS    = 8,
    parameter int HAS_ICACHE = 1,
    parameter int AW         = 4
) (
    input  wire logic              i_is_read,
    input  wire logic              i_is_double,
    input  wire logic [2:0]        i_opcode1,
    input  wire logic [3:0]        i_crn,
    input  wire logic [3:0]        i_crm,
    input  wire logic [2:0]        i_opcode2,
    input  wire logic [31:0]       i_main_id,
    input  wire logic [31:0]       i_cache_type_id,
    input  wire logic [31:0]       i_ctrl,
    output cp15m_pkg::t_dec        o_dec,
    output logic      [AW-1:0]     o_ram_addr
);
    import cp15m_pkg::*;

    logic crm_57;
    logic in_range;
    logic nop_op;

    assign crm_57   = (i_crm == 4'd5) || (i_crm == 4'd7);
    assign in_range = {1'b0, i_crm} < 5'(REGIONS);
    assign nop_op   = ((i_crm == 4'd10) && (i_opcode2 == 3'd0 || i_opcode2 == 3'd1 ||
                                            i_opcode2 == 3'd2 || i_opcode2 == 3'd4)) ||
                      ((i_crm == 4'd6) && (i_opcode2 <= 3'd2)) ||
                      ((i_crm == 4'd2) && (i_opcode2 == 3'd5)) ||
                      ((i_crm == 4'd5) && (i_opcode2 == 3'd6)) ||
                      ((i_crm == 4'd0) && (i_opcode2 == 3'd4)) ||
                      ((i_crm == 4'd14) && (i_opcode2 == 3'd2));

    always_comb begin
        o_dec      = '0;
        o_dec.rd   = i_is_read;
        o_ram_addr = AW'(i_crm);
        if (i_opcode1 == 3'd0 && !i_is_double) begin
            unique case (i_crn)
                CRN_ID: begin
                    if (i_is_read && i_crm == 4'd0 && i_opcode2 == 3'd0) begin
                        o_dec.ok  = 1'b1;
                        o_dec.imm = i_main_id;
                    end else if (i_is_read && i_crm == 4'd0 && i_opcode2 == 3'd1) begin
                        o_dec.ok  = 1'b1;
                        o_dec.imm = i_cache_type_id;
                    end
                end
                CRN_CTRL: begin
                    if (i_opcode2 == 3'd0 && i_crm == 4'd0) begin
                        o_dec.ok      = 1'b1;
                        o_dec.ctrl_we = !i_is_read;
                        o_dec.imm     = i_ctrl | CTRL_READ_SET;
                    end
                end
                CRN_CACHE, CRN_BUFFER, CRN_AP: begin
                    o_dec.ok     = 1'b1;
                    o_dec.ram_we = !i_is_read;
                    o_dec.ram_re = i_is_read;
                    if (i_crn == CRN_CACHE) begin
                        o_ram_addr = AW'(REGIONS);
                    end else if (i_crn == CRN_BUFFER) begin
                        o_ram_addr = AW'(REGIONS + 1);
                    end else begin
                        o_ram_addr = AW'(REGIONS + 2);
                    end
                end
                CRN_REGION: begin
                    // out of range regions are accepted, ignore writes, read zero
                    o_dec.ok     = 1'b1;
                    o_dec.ram_we = in_range && !i_is_read;
                    o_dec.ram_re = in_range && i_is_read;
                end
                CRN_CACHOP: begin
                    if (crm_57 && (i_opcode2 == 3'd0 || i_opcode2 == 3'd2)) begin
                        o_dec.ok     = 1'b1;
                        o_dec.fl_all = (HAS_ICACHE != 0);
                    end else if (crm_57 && i_opcode2 == 3'd1) begin
                        o_dec.ok      = 1'b1;
                        o_dec.fl_line = (HAS_ICACHE != 0);
                    end else if (nop_op) begin
                        o_dec.ok = 1'b1;
                    end
                end
                CRN_LOCK: begin
                    if (i_crm == 4'd0 && (i_opcode2 == 3'd0 || i_opcode2 == 3'd1)) begin
                        o_dec.ok = 1'b1;
                    end
                end
                default: begin
                    o_dec.ok = 1'b0;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== hdl/cp15_mpu_coprocessor_regs.sv =====
// top level of the cp15 mpu coprocessor register block
// depends on cp15m_pkg, cp15m_if, cp15m_ram and cp15m_dec
//
//  channel | dir | handshake      | payload
//  i_req   | in  | valid / ready  | is_read, is_double, opcode1, CRn, CRm, opcode2, data
//  o_rsp   | out | valid / ready  | accepted, read_data, vectors, mpu, flush pulses/addr
//  apb     | in  | psel / penable | main_id at 0x0, cache_type_id at 0x4
//
// one item per cycle sustained while o_rsp is not stalled; an accepted item is registered
// in the middle stage, then in the output stage, which drives o_rsp.valid
// the read data comes from the register ram in the cycle after the item is taken
// writes to the ram and control register happen at acceptance, so a following
// read sees them through the ram's registered port without forwarding
// reset clears the entry valid bits at once; an unwritten entry reads as zero
// a stall on o_rsp holds the output and middle stage, the block then takes
// items only while the middle stage is free
`default_nettype none

module cp15_mpu_coprocessor_regs #(
    parameter int REGIONS    = 8,
    parameter int HAS_ICACHE = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cp15m_req_if.sink        i_req,
    cp15m_rsp_if.source      o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import cp15m_pkg::*;

    localparam int DEPTH = REGIONS + 3;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0] r_main_id;
    logic [31:0] r_cache_type_id;
    logic [31:0] r_ctrl;
    logic [31:0] n_ctrl;
    logic [DEPTH-1:0] r_vld;

    t_dec        dec;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;
    logic        in_acc;
    logic        out_free;
    logic        s1_move;

    // middle stage
    logic        r_s1_valid;
    t_dec        r_s1_dec;
    logic        r_s1_ent_vld;
    logic        r_s1_hv;
    logic        r_s1_mpu;
    logic [31:0] r_s1_fl_addr;

    // output stage
    logic        r_out_valid;
    logic        r_out_acc;
    logic [31:0] r_out_rdata;
    logic        r_out_hv;
    logic        r_out_mpu;
    logic        r_out_fl_all;
    logic        r_out_fl_line;
    logic [31:0] r_out_fl_addr;
    logic [31:0] s1_rdata;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_CACHE_TYPE) ? r_cache_type_id : r_main_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_id       <= '0;
            r_cache_type_id <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_MAIN_ID) begin
                r_main_id <= pwdata;
            end else begin
                r_cache_type_id <= pwdata;
            end
        end
    end

    cp15m_dec #(
        .REGIONS    (REGIONS),
        .HAS_ICACHE (HAS_ICACHE),
        .AW         (AW)
    ) u_dec (
        .i_is_read       (i_req.is_read),
        .i_is_double     (i_req.is_double),
        .i_opcode1       (i_req.opcode1),
        .i_crn           (i_req.primary_reg),
        .i_crm           (i_req.secondary_reg),
        .i_opcode2       (i_req.opcode2),
        .i_main_id       (r_main_id),
        .i_cache_type_id (r_cache_type_id),
        .i_ctrl          (r_ctrl),
        .o_dec           (dec),
        .o_ram_addr      (ram_addr)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;
    assign in_acc      = i_req.valid && i_req.ready;

    // region entries take the write mask, the other entries are plain words
    assign ram_wdata = (i_req.primary_reg == CRN_REGION)
                     ? (i_req.write_data & REGION_WRITE_MASK) : i_req.write_data;

    cp15m_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && dec.ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc && dec.ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_ctrl = r_ctrl;
        if (in_acc && dec.ctrl_we) begin
            n_ctrl = (i_req.write_data | CTRL_SET_MASK) & ~CTRL_CLEAR_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= CTRL_RESET;
            r_vld  <= '0;
        end else begin
            r_ctrl <= n_ctrl;
            if (in_acc && dec.ram_we) begin
                r_vld[ram_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_dec     <= dec;
            r_s1_ent_vld <= r_vld[ram_addr];
            r_s1_hv      <= n_ctrl[CTRL_HIVEC_BIT];
            r_s1_mpu     <= n_ctrl[CTRL_MPU_BIT];
            r_s1_fl_addr <= (dec.fl_line && !i_req.is_read) ? i_req.write_data : '0;
        end
    end

    always_comb begin
        s1_rdata = '0;
        if (r_s1_dec.ok && r_s1_dec.rd) begin
            if (r_s1_dec.ram_re) begin
                s1_rdata = r_s1_ent_vld ? ram_rdata : '0;
            end else begin
                s1_rdata = r_s1_dec.imm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_acc     <= r_s1_dec.ok;
            r_out_rdata   <= s1_rdata;
            r_out_hv      <= r_s1_hv;
            r_out_mpu     <= r_s1_mpu;
            r_out_fl_all  <= r_s1_dec.fl_all;
            r_out_fl_line <= r_s1_dec.fl_line;
            r_out_fl_addr <= r_s1_fl_addr;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.accepted          = r_out_acc;
    assign o_rsp.read_data         = r_out_rdata;
    assign o_rsp.high_vectors      = r_out_hv;
    assign o_rsp.mpu_enable        = r_out_mpu;
    assign o_rsp.icache_flush_all  = r_out_fl_all;
    assign o_rsp.icache_flush_line = r_out_fl_line;
    assign o_rsp.flush_address     = r_out_fl_addr;
endmodule

`default_nettype wire

// ===== hdl/cp15m_chk.sv =====
// port level checker for the cp15 mpu register block, bound to the top level
// depends on cp15_mpu_coprocessor_regs and its interfaces
`default_nettype none

module cp15m_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        i_accepted,
    input wire logic [31:0] i_read_data,
    input wire logic        i_fl_all,
    input wire logic        i_fl_line,
    input wire logic [31:0] i_fl_addr,
    input wire logic        i_hv,
    input wire logic        i_mpu
);
    // a flush only comes from an accepted transfer
    a_flush_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_fl_all || i_fl_line) |-> i_accepted)
        else $error("flush pulse on rejected item");

    a_flush_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_fl_all && i_fl_line))
        else $error("both flush pulses set");

    a_addr_only_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_fl_line |-> i_fl_addr == 32'd0)
        else $error("flush address without line flush");

    a_rdata_zero_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_accepted |-> i_read_data == 32'd0)
        else $error("read data on rejected item");

    // control outputs hold while a response is stalled
    a_ctrl_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_hv) && $stable(i_mpu))
        else $error("control outputs changed under stall");
endmodule

bind cp15_mpu_coprocessor_regs cp15m_chk u_cp15m_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_accepted  (o_rsp.accepted),
    .i_read_data (o_rsp.read_data),
    .i_fl_all    (o_rsp.icache_flush_all),
    .i_fl_line   (o_rsp.icache_flush_line),
    .i_fl_addr   (o_rsp.flush_address),
    .i_hv        (o_rsp.high_vectors),
    .i_mpu       (o_rsp.mpu_enable)
);

`default_nettype wire

// ===== bench/tb_cp15_mpu_coprocessor_regs.sv =====
// self-checking bench for the cp15 mpu coprocessor register block
// needs cp15m_pkg, cp15m_if and the block's rtl; a directed table, then random phases
// run under varied idling, each result checked against an in-bench model or a row's fixed result
`timescale 1ns / 1ps

module tb_cp15_mpu_coprocessor_regs;
    import cp15m_pkg::*;

    localparam int REGIONS    = 8;
    localparam int HAS_ICACHE = 1;

    // register and opcode2 codes for the id, lock and cache operations
    localparam logic [3:0] CRM_WAIT         = 4'd0;
    localparam logic [3:0] CRM_PREFETCH     = 4'd2;
    localparam logic [3:0] CRM_IC_INV       = 4'd5;
    localparam logic [3:0] CRM_DC_INV       = 4'd6;
    localparam logic [3:0] CRM_IDC_INV      = 4'd7;
    localparam logic [3:0] CRM_DC_CLEAN     = 4'd10;
    localparam logic [3:0] CRM_DC_CLEAN_INV = 4'd14;
    localparam logic [3:0] CRN_UNUSED       = 4'd15;

    localparam logic [2:0] OP2_MAIN_ID     = 3'd0;
    localparam logic [2:0] OP2_CACHE_TYPE  = 3'd1;
    localparam logic [2:0] OP2_LOCK_DATA   = 3'd0;
    localparam logic [2:0] OP2_LOCK_INSN   = 3'd1;
    localparam logic [2:0] OP2_INV_ALL     = 3'd0;
    localparam logic [2:0] OP2_INV_LINE    = 3'd1;
    localparam logic [2:0] OP2_INV_ALL_ALT = 3'd2;
    localparam logic [2:0] OP2_WAIT        = 3'd4;
    localparam logic [2:0] OP2_PREFETCH    = 3'd5;
    localparam logic [2:0] OP2_BTB         = 3'd6;

    typedef struct packed {
        logic        is_read;
        logic        is_double;
        logic [2:0]  opcode1;
        logic [3:0]  crn;
        logic [3:0]  crm;
        logic [2:0]  opcode2;
        logic [31:0] wdata;
    } cop_xfer_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] read_data;
        logic        high_vectors;
        logic        mpu_enable;
        logic        flush_all;
        logic        flush_line;
        logic [31:0] flush_addr;
    } cop_result_t;

    typedef struct {
        cop_xfer_t   xfer;
        bit          typed;
        cop_result_t res;
    } directed_row_t;

    localparam cop_result_t ACK0   = '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0};
    localparam cop_result_t REJECT = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    cp15m_req_if req_ch ();
    cp15m_rsp_if rsp_ch ();

    cp15_mpu_coprocessor_regs #(
        .REGIONS    (REGIONS),
        .HAS_ICACHE (HAS_ICACHE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers
    logic [31:0] main_id_reg, cache_type_reg, ctrl_reg;
    logic [31:0] cacheable_reg, bufferable_reg, perm_reg;
    logic [31:0] region_cfg [REGIONS];

    cop_result_t pending_results [$];
    directed_row_t directed_rows [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int n_accepted    = 0;
    int n_flushes     = 0;
    int n_reads       = 0;

    function automatic cop_result_t predict_transfer(cop_xfer_t x);
        cop_result_t r;
        logic [31:0] v;
        logic ok;
        r  = '0;
        ok = 1'b0;
        v  = x.is_read ? 32'h0 : x.wdata;
        if (x.opcode1 == 3'd0 && !x.is_double) begin
            case (x.crn)
                CRN_ID: begin
                    if (x.is_read && x.crm == 4'd0 && x.opcode2 == OP2_MAIN_ID) begin
                        v  = main_id_reg;
                        ok = 1'b1;
                    end else if (x.is_read && x.crm == 4'd0 && x.opcode2 == OP2_CACHE_TYPE) begin
                        v  = cache_type_reg;
                        ok = 1'b1;
                    end
                end
                CRN_CTRL: begin
                    if (x.crm == 4'd0 && x.opcode2 == 3'd0) begin
                        if (x.is_read) v = ctrl_reg | CTRL_READ_SET;
                        else ctrl_reg = (v | CTRL_SET_MASK) & ~CTRL_CLEAR_MASK;
                        ok = 1'b1;
                    end
                end
                CRN_CACHE: begin
                    if (x.is_read) v = cacheable_reg; else cacheable_reg = v;
                    ok = 1'b1;
                end
                CRN_BUFFER: begin
                    if (x.is_read) v = bufferable_reg; else bufferable_reg = v;
                    ok = 1'b1;
                end
                CRN_AP: begin
                    if (x.is_read) v = perm_reg; else perm_reg = v;
                    ok = 1'b1;
                end
                CRN_REGION: begin
                    // regions past the implemented count read as zero and drop writes
                    if (x.crm < REGIONS) begin
                        if (x.is_read) v = region_cfg[x.crm[$clog2(REGIONS)-1:0]];
                        else region_cfg[x.crm[$clog2(REGIONS)-1:0]] = v & REGION_WRITE_MASK;
                    end else if (x.is_read) begin
                        v = 32'h0;
                    end
                    ok = 1'b1;
                end
                CRN_CACHOP: begin
                    // a cache op issued as a read behaves as a write of zero
                    if ((x.crm == CRM_IC_INV || x.crm == CRM_IDC_INV) &&
                        (x.opcode2 == OP2_INV_ALL || x.opcode2 == OP2_INV_ALL_ALT)) begin
                        r.flush_all = (HAS_ICACHE != 0);
                        ok = 1'b1;
                    end else if ((x.crm == CRM_IC_INV || x.crm == CRM_IDC_INV) &&
                                 x.opcode2 == OP2_INV_LINE) begin
                        r.flush_line = (HAS_ICACHE != 0);
                        if (r.flush_line) r.flush_addr = v;
                        ok = 1'b1;
                    end else if ((x.crm == CRM_DC_CLEAN && (x.opcode2 <= OP2_INV_ALL_ALT ||
                                                            x.opcode2 == OP2_WAIT)) ||
                                 (x.crm == CRM_DC_INV && x.opcode2 <= OP2_INV_ALL_ALT) ||
                                 (x.crm == CRM_PREFETCH && x.opcode2 == OP2_PREFETCH) ||
                                 (x.crm == CRM_IC_INV && x.opcode2 == OP2_BTB) ||
                                 (x.crm == CRM_WAIT && x.opcode2 == OP2_WAIT) ||
                                 (x.crm == CRM_DC_CLEAN_INV &&
                                  x.opcode2 == OP2_INV_ALL_ALT)) begin
                        ok = 1'b1;
                    end
                end
                CRN_LOCK: begin
                    if (x.crm == 4'd0 &&
                        (x.opcode2 == OP2_LOCK_DATA || x.opcode2 == OP2_LOCK_INSN)) begin
                        ok = 1'b1;
                        v  = 32'h0;
                    end
                end
                default: ;
            endcase
        end
        r.accepted     = ok;
        r.read_data    = (ok && x.is_read) ? v : 32'h0;
        r.high_vectors = ctrl_reg[CTRL_HIVEC_BIT];
        r.mpu_enable   = ctrl_reg[CTRL_MPU_BIT];
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 32'h0;
        if (k == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // mostly well-formed transfers, with a share of noise on every field
    function automatic cop_xfer_t random_transfer();
        cop_xfer_t x;
        int k, c;
        k = $urandom_range(99);
        x.is_read   = 1'($urandom_range(1));
        x.is_double = (k < 4);
        x.opcode1   = (k >= 4 && k < 8) ? 3'($urandom_range(7, 1)) : 3'd0;
        x.wdata     = random_word();
        x.crm       = 4'($urandom_range(15));
        x.opcode2   = 3'($urandom_range(7));
        k = $urandom_range(99);
        if (k < 8)       x.crn = CRN_ID;
        else if (k < 24) x.crn = CRN_CTRL;
        else if (k < 31) x.crn = CRN_CACHE;
        else if (k < 37) x.crn = CRN_BUFFER;
        else if (k < 43) x.crn = CRN_AP;
        else if (k < 62) x.crn = CRN_REGION;
        else if (k < 86) x.crn = CRN_CACHOP;
        else if (k < 92) x.crn = CRN_LOCK;
        else             x.crn = 4'($urandom_range(15));
        if ($urandom_range(99) < 80) begin
            case (x.crn)
                CRN_ID: begin
                    x.crm     = 4'd0;
                    x.opcode2 = $urandom_range(1) ? OP2_CACHE_TYPE : OP2_MAIN_ID;
                end
                CRN_CTRL: begin
                    x.crm     = 4'd0;
                    x.opcode2 = 3'd0;
                end
                CRN_REGION: x.crm = 4'($urandom_range(REGIONS - 1));
                CRN_LOCK: begin
                    x.crm     = 4'd0;
                    x.opcode2 = $urandom_range(1) ? OP2_LOCK_INSN : OP2_LOCK_DATA;
                end
                CRN_CACHOP: begin
                    c = $urandom_range(8);
                    case (c)
                        0: begin x.crm = CRM_IC_INV;  x.opcode2 = OP2_INV_ALL;     end
                        1: begin x.crm = CRM_IDC_INV; x.opcode2 = OP2_INV_ALL_ALT; end
                        2: begin
                            x.crm     = $urandom_range(1) ? CRM_IC_INV : CRM_IDC_INV;
                            x.opcode2 = OP2_INV_LINE;
                        end
                        3: begin
                            x.crm     = CRM_DC_CLEAN;
                            x.opcode2 = $urandom_range(3) == 3 ? OP2_WAIT
                                                               : 3'($urandom_range(2));
                        end
                        4: begin x.crm = CRM_DC_INV;  x.opcode2 = 3'($urandom_range(2)); end
                        5: begin x.crm = CRM_PREFETCH; x.opcode2 = OP2_PREFETCH;  end
                        6: begin x.crm = CRM_IC_INV;  x.opcode2 = OP2_BTB;        end
                        7: begin x.crm = CRM_WAIT;    x.opcode2 = OP2_WAIT;       end
                        default: begin
                            x.crm     = CRM_DC_CLEAN_INV;
                            x.opcode2 = OP2_INV_ALL_ALT;
                        end
                    endcase
                end
                default: ;
            endcase
        end
        return x;
    endfunction

    task automatic send_item(cop_xfer_t x, bit typed, cop_result_t fixed);
        cop_result_t pred;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.is_read       <= x.is_read;
        req_ch.is_double     <= x.is_double;
        req_ch.opcode1       <= x.opcode1;
        req_ch.primary_reg   <= x.crn;
        req_ch.secondary_reg <= x.crm;
        req_ch.opcode2       <= x.opcode2;
        req_ch.write_data    <= x.wdata;
        do @(posedge i_clk); while (!req_ch.ready);
        pred = predict_transfer(x);
        pending_results.push_back(typed ? fixed : pred);
        items_sent++;
    endtask

    // lower valid, wait for every result, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_MAIN_ID) main_id_reg = value;
        else cache_type_reg = value;
        @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checker
    initial begin
        cop_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (rsp_ch.accepted) n_accepted++;
                if (rsp_ch.icache_flush_all || rsp_ch.icache_flush_line) n_flushes++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got accepted %b data %h",
                             $time, rsp_ch.accepted, rsp_ch.read_data);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(rsp_ch.accepted));
                    check_field("read_data", want.read_data, rsp_ch.read_data);
                    check_field("high_vectors", 32'(want.high_vectors),
                                32'(rsp_ch.high_vectors));
                    check_field("mpu_enable", 32'(want.mpu_enable), 32'(rsp_ch.mpu_enable));
                    check_field("icache_flush_all", 32'(want.flush_all),
                                32'(rsp_ch.icache_flush_all));
                    check_field("icache_flush_line", 32'(want.flush_line),
                                32'(rsp_ch.icache_flush_line));
                    check_field("flush_address", want.flush_addr, rsp_ch.flush_address);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [31:0] cfg_main, cfg_ctype;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.is_read       = 1'b0;
        req_ch.is_double     = 1'b0;
        req_ch.opcode1       = '0;
        req_ch.primary_reg   = '0;
        req_ch.secondary_reg = '0;
        req_ch.opcode2       = '0;
        req_ch.write_data    = '0;

        main_id_reg    = '0;
        cache_type_reg = '0;
        ctrl_reg       = CTRL_RESET;
        cacheable_reg  = '0;
        bufferable_reg = '0;
        perm_reg       = '0;
        foreach (region_cfg[i]) region_cfg[i] = '0;

        directed_rows = '{
            '{'{1'b1, 1'b0, 3'd0, CRN_ID, 4'd0, OP2_MAIN_ID, 32'h0}, 1'b1, ACK0},
            '{'{1'b1, 1'b0, 3'd0, CRN_ID, 4'd0, OP2_CACHE_TYPE, 32'h0}, 1'b1, ACK0},
            '{'{1'b1, 1'b0, 3'd0, CRN_CTRL, 4'd0, 3'd0, 32'hffff_ffff}, 1'b1,
              '{1'b1, 32'h7a, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{'{1'b0, 1'b0, 3'd0, CRN_CTRL, 4'd0, 3'd0, 32'hffff_ffff}, 1'b1,
              '{1'b1, 32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0}},
            '{'{1'b1, 1'b0, 3'd0, CRN_CTRL, 4'd0, 3'd0, 32'h0}, 1'b0, '0},
            '{'{1'b0, 1'b0, 3'd0, CRN_CTRL, 4'd0, 3'd0, 32'h0}, 1'b1, ACK0},
            '{'{1'b0, 1'b0, 3'd0, CRN_CACHE, 4'd15, 3'd7, 32'hffff_ffff}, 1'b0, '0},
            '{'{1'b1, 1'b0, 3'd0, CRN_CACHE, 4'd0, 3'd0, 32'h0}, 1'b0, '0},
            '{'{1'b0, 1'b0, 3'd0, CRN_BUFFER, 4'd9, 3'd3, 32'ha5a5_a5a5}, 1'b0, '0},
            '{'{1'b1, 1'b0, 3'd0, CRN_BUFFER, 4'd0, 3'd0, 32'h0}, 1'b0, '0},
            '{'{1'b0, 1'b0, 3'd0, CRN_AP, 4'd3, 3'd2, 32'h5a5a_5a5a}, 1'b0, '0},
            '{'{1'b1, 1'b0, 3'd0, CRN_AP, 4'd0, 3'd0, 32'h0}, 1'b0, '0},
            '{'{1'b0, 1'b0, 3'd0, CRN_REGION, 4'd7, 3'd0, 32'hffff_ffff}, 1'b0, '0},
            '{'{1'b1, 1'b0, 3'd0, CRN_REGION, 4'd7, 3'd0, 32'h0}, 1'b1,
              '{1'b1, 32'hffff_f07f, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{'{1'b0, 1'b0, 3'd0, CRN_REGION, 4'd15, 3'd0, 32'hffff_ffff}, 1'b0, '0},
            '{'{1'b1, 1'b0, 3'd0, CRN_REGION, 4'd8, 3'd0, 32'h0}, 1'b1, ACK0},
            '{'{1'b0, 1'b0, 3'd0, CRN_CACHOP, CRM_IC_INV, OP2_INV_ALL, 32'h0}, 1'b1,
              '{1'b1, 32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
            '{'{1'b1, 1'b0, 3'd0, CRN_CACHOP, CRM_IDC_INV, OP2_INV_ALL_ALT, 32'h0}, 1'b1,
              '{1'b1, 32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
            '{'{1'b0, 1'b0, 3'd0, CRN_CACHOP, CRM_IDC_INV, OP2_INV_LINE, 32'hffff_ffc0},
              1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hffff_ffc0}},
            // line flush issued as a read targets address zero
            '{'{1'b1, 1'b0, 3'd0, CRN_CACHOP, CRM_IC_INV, OP2_INV_LINE, 32'h1234_5678},
              1'b1, '{1'b1, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0}},
            '{'{1'b0, 1'b0, 3'd0, CRN_CACHOP, CRM_DC_CLEAN, OP2_WAIT, 32'hffff_ffff}, 1'b1,
              ACK0},
            '{'{1'b1, 1'b0, 3'd0, CRN_LOCK, 4'd0, OP2_LOCK_INSN, 32'h0}, 1'b1, ACK0},
            '{'{1'b1, 1'b0, 3'd7, CRN_CTRL, 4'd0, 3'd0, 32'h0}, 1'b1, REJECT},
            '{'{1'b0, 1'b1, 3'd0, CRN_CTRL, 4'd0, 3'd0, 32'hffff_ffff}, 1'b1, REJECT},
            '{'{1'b0, 1'b0, 3'd0, CRN_ID, 4'd0, OP2_MAIN_ID, 32'hffff_ffff}, 1'b1, REJECT},
            '{'{1'b1, 1'b0, 3'd0, CRN_UNUSED, 4'd0, 3'd0, 32'h0}, 1'b1, REJECT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].xfer, directed_rows[i].typed, directed_rows[i].res);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    cfg_main = 32'hffff_ffff; cfg_ctype = 32'h0;
                    send_idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    cfg_main = 32'h0; cfg_ctype = 32'hffff_ffff;
                    send_idle_pct = 84; stall_pct = 0;
                end
                2: begin
                    cfg_main = $urandom; cfg_ctype = $urandom;
                    send_idle_pct = 0;  stall_pct = 84;
                end
                default: begin
                    cfg_main = $urandom; cfg_ctype = $urandom;
                    send_idle_pct = 32; stall_pct = 32;
                end
            endcase
            cfg_write(CFG_MAIN_ID, cfg_main);
            cfg_write(CFG_CACHE_TYPE, cfg_ctype);
            // long hold-off so the block backs up onto its input
            if (phase == 0) hold_left = 60;
            for (int n = 0; n < 232; n++) send_item(random_transfer(), 1'b0, '0);
            settle();
        end

        $display("%0d transfers sent, %0d results checked: %0d accepted, %0d flush pulses",
                 items_sent, results_seen, n_accepted, n_flushes);
        $display("covered id, control, protection and region registers, cache ops, %s",
                 "rejects and four idling mixes");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cp15m_pkg.sv
hdl/cp15m_if.sv
hdl/cp15m_ram.sv
hdl/cp15m_dec.sv
hdl/cp15_mpu_coprocessor_regs.sv
hdl/cp15m_chk.sv
bench/tb_cp15_mpu_coprocessor_regs.sv
